FILE: src/dual_force_sensor_filter_packetizer_core_assert.svh
// assertion macros shared by the force filter modules
`ifndef DUAL_FORCE_SENSOR_FILTER_PACKETIZER_CORE_ASSERT_SVH
`define DUAL_FORCE_SENSOR_FILTER_PACKETIZER_CORE_ASSERT_SVH

// same-cycle implication
`define DFSF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfsf assertion failed");

// next-cycle implication
`define DFSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfsf assertion failed");

// condition that must never occur
`define DFSF_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("dfsf assertion failed");

`endif

FILE: src/dfsf_pkg.sv
// shared types and constants of the dual force sensor filter
package dfsf_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int SAMPLE_WIDTH        = 16;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int CSR_DATA_BITS       = 32;
   localparam int FORCE_BITS          = 20;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_ALPHA = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_GAIN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_OFFSET  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT_GAIN   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT_OFFSET = 3'd4;

   // register reset values
   localparam logic [16:0] ALPHA_RESET        = 17'd1074;
   localparam logic [31:0] LEFT_GAIN_RESET    = 32'sd2483956;
   localparam logic [24:0] LEFT_OFFSET_RESET  = -25'sd1244756;
   localparam logic [31:0] RIGHT_GAIN_RESET   = 32'sd2878248;
   localparam logic [24:0] RIGHT_OFFSET_RESET = -25'sd1443150;

   localparam logic [16:0]           ALPHA_ONE = 17'h10000;
   localparam logic [FORCE_BITS-1:0] FORCE_MAX = 20'd1000000;

   localparam logic [7:0] MARK_LEFT  = 8'h4C;
   localparam logic [7:0] MARK_RIGHT = 8'h52;

   // positions within the eight-byte frame
   localparam logic [2:0] POS_MARK_L = 3'd0;
   localparam logic [2:0] POS_L_B0   = 3'd1;
   localparam logic [2:0] POS_L_B1   = 3'd2;
   localparam logic [2:0] POS_L_B2   = 3'd3;
   localparam logic [2:0] POS_MARK_R = 3'd4;
   localparam logic [2:0] POS_R_B0   = 3'd5;
   localparam logic [2:0] POS_R_B1   = 3'd6;
   localparam logic [2:0] POS_R_B2   = 3'd7;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample_left;
      logic [SAMPLE_WIDTH-1:0] sample_right;
   } req_item_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT_L,
      ST_FILT_R,
      ST_FORCE_L,
      ST_FORCE_R,
      ST_FINISH,
      ST_SEND
   } state_type;

   typedef enum logic [1:0] {
      MUL_FILT_L,
      MUL_FILT_R,
      MUL_FORCE_L,
      MUL_FORCE_R
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      mul_op_type mul_op;
      logic       upd_smooth_left;
      logic       upd_smooth_right;
      logic       upd_force_left;
      logic       upd_force_right;
      logic       byte_advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic byte_last;
   } ctrl_status_type;

endpackage

FILE: src/dfsf_ctrl.sv
// sequencer for filter, force and frame byte steps
module dfsf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dfsf_pkg::ctrl_cmd_type   cmd,
   input  dfsf_pkg::ctrl_status_type status
);

   `include "dual_force_sensor_filter_packetizer_core_assert.svh"

   dfsf_pkg::state_type state_ff;
   dfsf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfsf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfsf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dfsf_pkg::ST_FILT_L;
            end
         end
         dfsf_pkg::ST_FILT_L:  state_in = dfsf_pkg::ST_FILT_R;
         dfsf_pkg::ST_FILT_R:  state_in = dfsf_pkg::ST_FORCE_L;
         dfsf_pkg::ST_FORCE_L: state_in = dfsf_pkg::ST_FORCE_R;
         dfsf_pkg::ST_FORCE_R: state_in = dfsf_pkg::ST_FINISH;
         dfsf_pkg::ST_FINISH:  state_in = dfsf_pkg::ST_SEND;
         dfsf_pkg::ST_SEND: begin
            if (rsp_ready && status.byte_last) begin
               state_in = dfsf_pkg::ST_IDLE;
            end
         end
         default: state_in = dfsf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.mul_op = dfsf_pkg::MUL_FILT_L;
      case (state_ff)
         dfsf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         dfsf_pkg::ST_FILT_L: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = dfsf_pkg::MUL_FILT_L;
         end
         dfsf_pkg::ST_FILT_R: begin
            cmd.mul_en          = 1'b1;
            cmd.mul_op          = dfsf_pkg::MUL_FILT_R;
            cmd.upd_smooth_left = 1'b1;
         end
         dfsf_pkg::ST_FORCE_L: begin
            cmd.mul_en           = 1'b1;
            cmd.mul_op           = dfsf_pkg::MUL_FORCE_L;
            cmd.upd_smooth_right = 1'b1;
         end
         dfsf_pkg::ST_FORCE_R: begin
            cmd.mul_en         = 1'b1;
            cmd.mul_op         = dfsf_pkg::MUL_FORCE_R;
            cmd.upd_force_left = 1'b1;
         end
         dfsf_pkg::ST_FINISH: begin
            cmd.upd_force_right = 1'b1;
         end
         dfsf_pkg::ST_SEND: begin
            rsp_valid        = 1'b1;
            cmd.byte_advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `DFSF_ASSERT_NEVER(a_no_accept_while_sending, clock, reset, req_ready && rsp_valid)
   `DFSF_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_valid && req_ready,
      !req_ready && !rsp_valid)
   `DFSF_ASSERT_NEXT(a_last_byte_frees_input, clock, reset,
      rsp_valid && rsp_ready && status.byte_last, req_ready)

endmodule

FILE: src/dfsf_datapath.sv
// filter state, shared multiplier, force conversion and frame byte mux
module dfsf_datapath #(
   parameter int SAMPLE_BITS = dfsf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dfsf_pkg::req_item_type                  req_data,
   output dfsf_pkg::rsp_item_type                  rsp_data,
   input  logic                                    csr_we,
   input  logic [dfsf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dfsf_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  dfsf_pkg::ctrl_cmd_type                  cmd,
   output dfsf_pkg::ctrl_status_type               status
);

   `include "dual_force_sensor_filter_packetizer_core_assert.svh"

   // configuration
   logic [16:0] alpha_ff;
   logic [31:0] left_gain_ff;
   logic [24:0] left_offset_ff;
   logic [31:0] right_gain_ff;
   logic [24:0] right_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff        <= dfsf_pkg::ALPHA_RESET;
         left_gain_ff    <= dfsf_pkg::LEFT_GAIN_RESET;
         left_offset_ff  <= dfsf_pkg::LEFT_OFFSET_RESET;
         right_gain_ff   <= dfsf_pkg::RIGHT_GAIN_RESET;
         right_offset_ff <= dfsf_pkg::RIGHT_OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dfsf_pkg::CSR_FILTER_ALPHA: alpha_ff        <= csr_wdata[16:0];
            dfsf_pkg::CSR_LEFT_GAIN:    left_gain_ff    <= csr_wdata;
            dfsf_pkg::CSR_LEFT_OFFSET:  left_offset_ff  <= csr_wdata[24:0];
            dfsf_pkg::CSR_RIGHT_GAIN:   right_gain_ff   <= csr_wdata;
            dfsf_pkg::CSR_RIGHT_OFFSET: right_offset_ff <= csr_wdata[24:0];
            default: ;
         endcase
      end
   end

   // latched samples, only the low SAMPLE_BITS bits matter
   logic [SAMPLE_BITS-1:0] sample_left_ff;
   logic [SAMPLE_BITS-1:0] sample_right_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_left_ff  <= req_data.sample_left[SAMPLE_BITS-1:0];
         sample_right_ff <= req_data.sample_right[SAMPLE_BITS-1:0];
      end
   end

   logic [31:0]                     smooth_left_ff;
   logic [31:0]                     smooth_right_ff;
   logic [dfsf_pkg::FORCE_BITS-1:0] held_left_ff;
   logic [dfsf_pkg::FORCE_BITS-1:0] held_right_ff;
   logic [2:0]                      byte_index_ff;
   logic signed [65:0]              prod_ff;

   // multiplier operand selection
   logic                   is_right;
   logic                   is_force;
   logic [SAMPLE_BITS-1:0] sample_sel;
   logic [31:0]            smooth_sel;
   logic [31:0]            x_val;
   logic signed [32:0]     diff;
   logic [16:0]            alpha_eff;
   logic [31:0]            gain_sel;
   logic signed [32:0]     mul_a;
   logic signed [32:0]     mul_b;
   logic signed [65:0]     prod_in;

   always_comb begin
      is_right   = (cmd.mul_op == dfsf_pkg::MUL_FILT_R) ||
                   (cmd.mul_op == dfsf_pkg::MUL_FORCE_R);
      is_force   = (cmd.mul_op == dfsf_pkg::MUL_FORCE_L) ||
                   (cmd.mul_op == dfsf_pkg::MUL_FORCE_R);
      sample_sel = is_right ? sample_right_ff : sample_left_ff;
      smooth_sel = is_right ? smooth_right_ff : smooth_left_ff;
      gain_sel   = is_right ? right_gain_ff : left_gain_ff;
      x_val      = 32'(sample_sel) << 16;
      diff       = $signed({1'b0, x_val}) - $signed({1'b0, smooth_sel});
      alpha_eff  = (alpha_ff > dfsf_pkg::ALPHA_ONE) ? dfsf_pkg::ALPHA_ONE : alpha_ff;
      if (is_force) begin
         mul_a = $signed({gain_sel[31], gain_sel});
         mul_b = $signed({1'b0, smooth_sel});
      end else begin
         mul_a = $signed({16'b0, alpha_eff});
         mul_b = diff;
      end
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // filter update: y + floor((alpha*d + 2^15) / 2^16), modulo 2^32
   logic [65:0] round_sum;
   logic [31:0] smooth_upd;

   always_comb begin
      round_sum  = prod_ff + 66'sd32768;
      smooth_upd = (cmd.upd_smooth_right ? smooth_right_ff : smooth_left_ff)
                   + round_sum[47:16];
   end

   // force: floor(gain*y / 2^32) + offset + round bit, then clamp
   logic [24:0]                     offset_sel;
   logic [34:0]                     force_sum;
   logic [dfsf_pkg::FORCE_BITS-1:0] force_sat;

   always_comb begin
      offset_sel = cmd.upd_force_right ? right_offset_ff : left_offset_ff;
      force_sum  = {prod_ff[65], prod_ff[65:32]}
                   + {{10{offset_sel[24]}}, offset_sel}
                   + 35'(prod_ff[31]);
      if (force_sum[34]) begin
         force_sat = '0;
      end else if (force_sum > 35'(dfsf_pkg::FORCE_MAX)) begin
         force_sat = dfsf_pkg::FORCE_MAX;
      end else begin
         force_sat = force_sum[dfsf_pkg::FORCE_BITS-1:0];
      end
   end

   logic [31:0]                     smooth_left_in;
   logic [31:0]                     smooth_right_in;
   logic [dfsf_pkg::FORCE_BITS-1:0] held_left_in;
   logic [dfsf_pkg::FORCE_BITS-1:0] held_right_in;
   logic [2:0]                      byte_index_in;

   always_comb begin
      smooth_left_in  = cmd.upd_smooth_left  ? smooth_upd : smooth_left_ff;
      smooth_right_in = cmd.upd_smooth_right ? smooth_upd : smooth_right_ff;
      held_left_in    = cmd.upd_force_left   ? force_sat  : held_left_ff;
      held_right_in   = cmd.upd_force_right  ? force_sat  : held_right_ff;
      // wraps to zero after the last byte
      byte_index_in   = cmd.byte_advance ? byte_index_ff + 3'd1 : byte_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_left_ff  <= '0;
         smooth_right_ff <= '0;
         held_left_ff    <= '0;
         held_right_ff   <= '0;
         byte_index_ff   <= '0;
      end else begin
         smooth_left_ff  <= smooth_left_in;
         smooth_right_ff <= smooth_right_in;
         held_left_ff    <= held_left_in;
         held_right_ff   <= held_right_in;
         byte_index_ff   <= byte_index_in;
      end
   end

   // frame byte mux
   always_comb begin
      case (byte_index_ff)
         dfsf_pkg::POS_MARK_L: rsp_data.frame_byte = dfsf_pkg::MARK_LEFT;
         dfsf_pkg::POS_L_B0:   rsp_data.frame_byte = held_left_ff[7:0];
         dfsf_pkg::POS_L_B1:   rsp_data.frame_byte = held_left_ff[15:8];
         dfsf_pkg::POS_L_B2:   rsp_data.frame_byte = {4'b0, held_left_ff[19:16]};
         dfsf_pkg::POS_MARK_R: rsp_data.frame_byte = dfsf_pkg::MARK_RIGHT;
         dfsf_pkg::POS_R_B0:   rsp_data.frame_byte = held_right_ff[7:0];
         dfsf_pkg::POS_R_B1:   rsp_data.frame_byte = held_right_ff[15:8];
         dfsf_pkg::POS_R_B2:   rsp_data.frame_byte = {4'b0, held_right_ff[19:16]};
         default:              rsp_data.frame_byte = dfsf_pkg::MARK_LEFT;
      endcase
      rsp_data.frame_last = (byte_index_ff == dfsf_pkg::POS_R_B2);
      status.byte_last    = (byte_index_ff == dfsf_pkg::POS_R_B2);
   end

   `DFSF_ASSERT_NEVER(a_force_in_range, clock, reset,
      (held_left_ff > dfsf_pkg::FORCE_MAX) || (held_right_ff > dfsf_pkg::FORCE_MAX))

endmodule

FILE: src/dual_force_sensor_filter_packetizer_core.sv
// Dual force sensor filter and frame builder. Each accepted item holds one left and one
// right converter sample; both channels pass a first-order low-pass filter (Q16.16 state),
// a gain and offset stage, rounding and clamping to 0..1000000 (0.1 g units), and the block
// then sends an eight-byte frame: 'L', three little-endian force bytes, 'R', three bytes,
// with frame_last set on the eighth byte. One 33x33 multiplier is shared by the two filter
// updates and the two force products, so after the accept an item steps through the
// filter-left, filter-right, force-left, force-right and finish states before its bytes are
// sent. A new item is taken only once the previous frame has been fully sent. Registers
// are written through csr_we/csr_index/csr_wdata, and the user must do so only while the
// block is idle; the block does not enforce this. Writes to unused indexes are ignored.
module dual_force_sensor_filter_packetizer_core #(
   parameter int SAMPLE_BITS = dfsf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dfsf_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dfsf_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_we,
   input  logic [dfsf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dfsf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   dfsf_pkg::ctrl_cmd_type    cmd;
   dfsf_pkg::ctrl_status_type status;

   dfsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dfsf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
